// ----- design/hyperlink_descriptor_parser_top_defines.svh -----
// Assertion macros used by the hyperlink descriptor parser checker
`ifndef HYPERLINK_DESCRIPTOR_PARSER_TOP_DEFINES_SVH
`define HYPERLINK_DESCRIPTOR_PARSER_TOP_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define HDP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define HDP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/hdp_pkg.sv -----
// Types, codes and constants of the hyperlink descriptor parser
package hdp_pkg;

    localparam int CFG_AW   = 3;
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = 2;
    localparam int REC_MAX  = 13;
    localparam int TDATA_W  = 152;
    localparam int TUSER_W  = 2;

    localparam logic [0:0] REG_EXPECTED_TAG = 1'b0;
    localparam logic [7:0] TAG_RESET        = 8'hC5;

    localparam logic [7:0] DEST_SERVICE     = 8'h01;
    localparam logic [7:0] DEST_EVENT       = 8'h02;
    localparam logic [7:0] DEST_MODULE      = 8'h03;
    localparam logic [7:0] DEST_CONTENT     = 8'h04;
    localparam logic [7:0] DEST_CONT_MODULE = 8'h05;
    localparam logic [7:0] DEST_ERT_NODE    = 8'h06;
    localparam logic [7:0] DEST_URI         = 8'h07;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LENGTH,
        PH_HEADER,
        PH_SELECT,
        PH_PRIVATE
    } t_phase;

    typedef enum logic [1:0] {
        KIND_RECORD,
        KIND_URI,
        KIND_PRIVATE,
        KIND_DONE
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_TAG,
        ST_ZERO_LEN,
        ST_OVERRUN,
        ST_SHORT
    } t_status;

    typedef struct packed {
        t_kind        kind;
        t_status      status;
        logic [7:0]   linkage_type;
        logic [7:0]   destination_type;
        logic [15:0]  first_id;
        logic [15:0]  second_id;
        logic [15:0]  third_id;
        logic [15:0]  event_number;
        logic [31:0]  content_number;
        logic [7:0]   component;
        logic [15:0]  module_number;
        logic [8:0]   byte_value;
    } t_result;

    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

    typedef struct packed {
        logic not_empty;
        logic has_room;
    } t_q_status;

    function automatic logic [3:0] rec_size(input logic [7:0] dest);
        logic [3:0] sz;
        unique case (dest)
            DEST_SERVICE:     sz = 4'd6;
            DEST_EVENT:       sz = 4'd8;
            DEST_MODULE:      sz = 4'd11;
            DEST_CONTENT:     sz = 4'd10;
            DEST_CONT_MODULE: sz = 4'd13;
            DEST_ERT_NODE:    sz = 4'd6;
            default:          sz = 4'd0;
        endcase
        return sz;
    endfunction

endpackage

// ----- design/hdp_front.sv -----
// Front end: byte parser, record assembly and result classification
module hdp_front
    import hdp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_req,
    input  logic        i_buffer_end,
    input  logic [7:0]  i_expected_tag,
    input  t_q_status   i_q_status,
    output t_push       o_push
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_body_count, n_body_count;
    logic [7:0]  r_body_length, n_body_length;
    logic [7:0]  r_link_kind, n_link_kind;
    logic [7:0]  r_dest_kind, n_dest_kind;
    logic [7:0]  r_sel_length, n_sel_length;
    logic [7:0]  r_sel_count, n_sel_count;
    logic [3:0]  r_rec_index, n_rec_index;
    logic [7:0]  r_rec [REC_MAX];

    logic        accept;
    logic [7:0]  bc;
    logic        last;
    logic [7:0]  sc;
    logic [3:0]  ri_inc;
    logic [3:0]  sz;
    logic        is_rec_dest;
    logic        rec_full;
    logic        sel_done;
    logic        hdr_sel_byte;
    logic        sel_overrun;
    logic        overrun;
    logic        rec_we;
    logic [7:0]  rb [REC_MAX];

    logic        item_v;
    t_kind       item_kind;
    logic        done_v;
    t_status     done_status;
    t_result     item_r;
    t_result     done_r;

    assign o_ready      = i_q_status.has_room;
    assign accept       = i_valid && o_ready;
    assign bc           = r_body_count + 8'd1;
    assign last         = bc >= r_body_length;
    assign sc           = r_sel_count + 8'd1;
    assign ri_inc       = r_rec_index + 4'd1;
    assign sz           = rec_size(r_dest_kind);
    assign is_rec_dest  = sz != 4'd0;
    assign rec_full     = is_rec_dest && (ri_inc >= sz);
    assign sel_done     = sc >= r_sel_length;
    assign hdr_sel_byte = (bc != 8'd1) && (bc != 8'd2);
    assign sel_overrun  = ({1'b0, i_data_byte} + 9'd3) > {1'b0, r_body_length};
    assign overrun      = (r_phase == PH_HEADER)
                          && ((hdr_sel_byte && sel_overrun) || (last && (bc < 8'd3)));
    assign rec_we       = accept && !i_start_req && (r_phase == PH_SELECT)
                          && is_rec_dest && (r_rec_index < 4'(REC_MAX));

    // outputs: what this beat produces
    always_comb begin
        item_v      = 1'b0;
        item_kind   = KIND_PRIVATE;
        done_v      = 1'b0;
        done_status = ST_OK;
        if (accept) begin
            if (i_start_req) begin
                done_v      = i_buffer_end || (i_data_byte != i_expected_tag);
                done_status = i_buffer_end ? ST_SHORT : ST_BAD_TAG;
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                    end
                    PH_LENGTH: begin
                        done_v      = (i_data_byte == 8'd0) || i_buffer_end;
                        done_status = (i_data_byte == 8'd0) ? ST_ZERO_LEN : ST_SHORT;
                    end
                    PH_HEADER, PH_SELECT, PH_PRIVATE: begin
                        if (r_phase == PH_SELECT && r_dest_kind == DEST_URI) begin
                            item_v    = 1'b1;
                            item_kind = KIND_URI;
                        end else if (r_phase == PH_SELECT && rec_full) begin
                            item_v    = 1'b1;
                            item_kind = KIND_RECORD;
                        end else if (r_phase == PH_PRIVATE) begin
                            item_v    = 1'b1;
                            item_kind = KIND_PRIVATE;
                        end
                        priority if (i_buffer_end && !last) begin
                            done_v      = 1'b1;
                            done_status = ST_SHORT;
                        end else if (overrun) begin
                            done_v      = 1'b1;
                            done_status = ST_OVERRUN;
                        end else if (last) begin
                            done_v      = 1'b1;
                            done_status = ST_OK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_body_count  = r_body_count;
        n_body_length = r_body_length;
        n_link_kind   = r_link_kind;
        n_dest_kind   = r_dest_kind;
        n_sel_length  = r_sel_length;
        n_sel_count   = r_sel_count;
        n_rec_index   = r_rec_index;
        if (accept) begin
            if (i_start_req) begin
                n_body_count  = 8'd0;
                n_body_length = 8'd0;
                n_link_kind   = 8'd0;
                n_dest_kind   = 8'd0;
                n_sel_length  = 8'd0;
                n_sel_count   = 8'd0;
                n_rec_index   = 4'd0;
                n_phase       = PH_LENGTH;
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                    end
                    PH_LENGTH: begin
                        n_body_length = i_data_byte;
                        n_phase       = PH_HEADER;
                    end
                    PH_HEADER: begin
                        n_body_count = bc;
                        if (bc == 8'd1) begin
                            n_link_kind = i_data_byte;
                        end else if (bc == 8'd2) begin
                            n_dest_kind = i_data_byte;
                        end else begin
                            n_sel_length = i_data_byte;
                            n_phase = (i_data_byte != 8'd0) ? PH_SELECT : PH_PRIVATE;
                        end
                    end
                    PH_SELECT: begin
                        n_body_count = bc;
                        n_sel_count  = sc;
                        if (is_rec_dest && r_dest_kind != DEST_URI) begin
                            n_rec_index = rec_full ? 4'd0 : ri_inc;
                        end
                        if (sel_done) begin
                            n_rec_index = 4'd0;
                            n_phase     = PH_PRIVATE;
                        end
                    end
                    PH_PRIVATE: begin
                        n_body_count = bc;
                    end
                    default: begin
                    end
                endcase
            end
            if (done_v) begin
                n_phase = PH_IDLE;
            end
        end
    end

    // record bytes with the current beat in place
    always_comb begin
        for (int i = 0; i < REC_MAX; i++) begin
            rb[i] = (r_rec_index == 4'(i)) ? i_data_byte : r_rec[i];
        end
    end

    always_comb begin
        item_r                  = '0;
        item_r.kind             = item_kind;
        item_r.status           = ST_OK;
        item_r.linkage_type     = n_link_kind;
        item_r.destination_type = n_dest_kind;
        if (item_kind == KIND_RECORD) begin
            item_r.first_id  = {rb[0], rb[1]};
            item_r.second_id = {rb[2], rb[3]};
            item_r.third_id  = {rb[4], rb[5]};
            if (r_dest_kind == DEST_EVENT || r_dest_kind == DEST_MODULE) begin
                item_r.event_number = {rb[6], rb[7]};
            end
            if (r_dest_kind == DEST_CONTENT || r_dest_kind == DEST_CONT_MODULE) begin
                item_r.content_number = {rb[6], rb[7], rb[8], rb[9]};
            end
            if (r_dest_kind == DEST_MODULE) begin
                item_r.component     = rb[8];
                item_r.module_number = {rb[9], rb[10]};
            end
            if (r_dest_kind == DEST_CONT_MODULE) begin
                item_r.component     = rb[10];
                item_r.module_number = {rb[11], rb[12]};
            end
        end else begin
            item_r.byte_value = {1'b0, i_data_byte};
        end

        done_r                  = '0;
        done_r.kind             = KIND_DONE;
        done_r.status           = done_status;
        done_r.linkage_type     = n_link_kind;
        done_r.destination_type = n_dest_kind;
        done_r.byte_value       = i_start_req ? 9'd0 : ({1'b0, n_body_length} + 9'd2);

        o_push.v0 = item_v || done_v;
        o_push.v1 = item_v && done_v;
        o_push.r0 = item_v ? item_r : done_r;
        o_push.r1 = done_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_body_count  <= 8'd0;
            r_body_length <= 8'd0;
            r_link_kind   <= 8'd0;
            r_dest_kind   <= 8'd0;
            r_sel_length  <= 8'd0;
            r_sel_count   <= 8'd0;
            r_rec_index   <= 4'd0;
        end else begin
            r_phase       <= n_phase;
            r_body_count  <= n_body_count;
            r_body_length <= n_body_length;
            r_link_kind   <= n_link_kind;
            r_dest_kind   <= n_dest_kind;
            r_sel_length  <= n_sel_length;
            r_sel_count   <= n_sel_count;
            r_rec_index   <= n_rec_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            r_rec[r_rec_index] <= i_data_byte;
        end
    end

endmodule

// ----- design/hdp_queue.sv -----
// Result queue between parser and output stage: two writes, one read per cycle
module hdp_queue
    import hdp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    input  logic      i_pop,
    output t_result   o_head,
    output t_q_status o_status
);

    t_result          r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [Q_AW:0]    r_count, n_count;
    logic [Q_AW-1:0]  wr_ptr_b;
    logic [Q_AW:0]    n_push;
    logic             pop_ok;

    assign wr_ptr_b  = r_wr_ptr + Q_AW'(1);
    assign pop_ok    = i_pop && (r_count != '0);
    assign n_push    = (Q_AW+1)'(i_push.v0) + (Q_AW+1)'(i_push.v1);
    assign n_wr_ptr  = r_wr_ptr + n_push[Q_AW-1:0];
    assign n_rd_ptr  = r_rd_ptr + Q_AW'(pop_ok);
    assign n_count   = r_count + n_push - (Q_AW+1)'(pop_ok);

    assign o_head             = r_mem[r_rd_ptr];
    assign o_status.not_empty = r_count != '0;
    assign o_status.has_room  = r_count <= (Q_AW+1)'(Q_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[wr_ptr_b] <= i_push.r1;
        end
    end

endmodule

// ----- design/hdp_back.sv -----
// Output stage: registered result beat toward the stream receiver
module hdp_back
    import hdp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_result            i_head,
    input  t_q_status          i_q_status,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [TDATA_W-1:0] o_tdata,
    output logic [TUSER_W-1:0] o_tuser
);

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_pop   = i_q_status.not_empty && (!r_valid || i_ready);
    assign n_valid = o_pop || (r_valid && !i_ready);
    assign o_valid = r_valid;
    assign o_tuser = r_res.kind;
    assign o_tdata = {
        4'd0,
        r_res.byte_value,
        r_res.module_number,
        r_res.component,
        r_res.content_number,
        r_res.event_number,
        r_res.third_id,
        r_res.second_id,
        r_res.first_id,
        r_res.destination_type,
        r_res.linkage_type,
        r_res.status
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_head;
        end
    end

endmodule

// ----- design/hyperlink_descriptor_parser_top.sv -----
// Hyperlink descriptor parser: byte stream in, records, URI/private bytes and done out
//
// Input stream: one descriptor byte per beat in tdata[7:0]; tuser marks the tag
// byte that opens a descriptor, tlast marks the last byte of the buffer.
// Output stream: one result per beat; tuser is the kind (record, URI byte,
// private byte, done), tdata carries the fields listed at the port.
// APB port: register expected_tag at address 0, reset value 0xC5; pready is
// tied high and writes take effect at the access cycle.
// Results pass through the result queue and the output register. Throughput:
// one input beat per cycle while tready is high; a beat that both emits a byte
// or record and closes the descriptor yields two results, and the output stage
// drains one per cycle while the receiver is ready.
// A four-entry result queue sits between parser and output register; input
// tready drops while fewer than two entries are free, so a stalled receiver
// backs up into the input, and nothing is lost.
// Reset (synchronous, active low) returns the parser to waiting for a tag,
// empties the queue and restores expected_tag.
module hyperlink_descriptor_parser_top
    import hdp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [CFG_AW-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [7:0]         i_s_axis_tdata,  // data_byte[7:0]
    input  logic               i_s_axis_tuser,  // start_req
    input  logic               i_s_axis_tlast,  // buffer_end
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // status[2:0] linkage_type[10:3] destination_type[18:11] first_id[34:19]
    // second_id[50:35] third_id[66:51] event_number[82:67] content_number[114:83]
    // component[122:115] module_number[138:123] byte_value[147:139] zero[151:148]
    output logic [TDATA_W-1:0] o_m_axis_tdata,
    output logic [TUSER_W-1:0] o_m_axis_tuser   // kind[1:0]
);

    logic [7:0] r_expected_tag;
    logic       cfg_we;
    t_push      push;
    t_result    head;
    t_q_status  q_status;
    logic       pop;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[CFG_AW-1:2] == REG_EXPECTED_TAG);
    assign prdata = (paddr[CFG_AW-1:2] == REG_EXPECTED_TAG) ? {24'd0, r_expected_tag}
                                                             : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_tag <= TAG_RESET;
        end else if (cfg_we) begin
            r_expected_tag <= pwdata[7:0];
        end
    end

    hdp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_data_byte    (i_s_axis_tdata),
        .i_start_req    (i_s_axis_tuser),
        .i_buffer_end   (i_s_axis_tlast),
        .i_expected_tag (r_expected_tag),
        .i_q_status     (q_status),
        .o_push         (push)
    );

    hdp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    hdp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_tdata    (o_m_axis_tdata),
        .o_tuser    (o_m_axis_tuser)
    );

endmodule

// ----- design/hdp_checker.sv -----
// Port-level checker for the hyperlink descriptor parser, bound to the top level
`include "hyperlink_descriptor_parser_top_defines.svh"

module hdp_checker
    import hdp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [CFG_AW-1:0]  paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               o_m_axis_tvalid,
    input logic               i_m_axis_tready,
    input logic [TDATA_W-1:0] o_m_axis_tdata,
    input logic [TUSER_W-1:0] o_m_axis_tuser
);

    `HDP_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "output beat changed while stalled")

    `HDP_ASSERT_NEXT(a_tag_readback, psel && penable && pwrite && (paddr[CFG_AW-1:2] == REG_EXPECTED_TAG), (paddr[CFG_AW-1:2] != REG_EXPECTED_TAG) || (prdata[7:0] == $past(pwdata[7:0])), "expected_tag readback mismatch")

    `HDP_ASSERT_NOW(a_status_on_done, o_m_axis_tvalid && (o_m_axis_tuser != KIND_DONE), o_m_axis_tdata[2:0] == ST_OK, "status set on a non-done beat")

    `HDP_ASSERT_NOW(a_byte_beat_clean, o_m_axis_tvalid && ((o_m_axis_tuser == KIND_URI) || (o_m_axis_tuser == KIND_PRIVATE)), o_m_axis_tdata[138:19] == '0, "record fields set on a byte beat")

endmodule

bind hyperlink_descriptor_parser_top hdp_checker u_hdp_checker (.*);

// ----- bench/hyperlink_descriptor_parser_top_tb.sv -----
// Self-checking bench for the hyperlink descriptor parser: byte stream in, predicted results out
module hyperlink_descriptor_parser_top_tb;
    import hdp_pkg::*;

    typedef struct {
        logic [7:0] dbyte;
        logic       sop;
        logic       eob;
        bit         hold;
    } t_beat_item;

    logic                i_clk;
    logic                i_rst_n  = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [CFG_AW-1:0]   paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [TUSER_W-1:0]  m_tuser;

    hyperlink_descriptor_parser_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // parser shadow state
    logic [7:0] pr_tag     = TAG_RESET;
    t_phase     pr_phase   = PH_IDLE;
    logic [7:0] pr_count   = '0;
    logic [7:0] pr_len     = '0;
    logic [7:0] pr_link    = '0;
    logic [7:0] pr_dest    = '0;
    logic [7:0] pr_sel_len = '0;
    logic [7:0] pr_sel_cnt = '0;
    int         pr_idx     = 0;
    logic [7:0] pr_rec [REC_MAX];

    t_result    pending_results [$];
    t_beat_item byte_backlog [$];
    t_beat_item nxt;
    t_result    got, want;

    int  bytes_queued = 0;
    int  beats_taken  = 0;
    int  fails        = 0;
    int  kind_seen [4];
    int  tags_used    = 0;
    int  in_gap       = 0;
    int  out_gap      = 0;
    bit  in_calm      = 1'b0;
    bit  out_calm     = 1'b0;

    function automatic int record_len(input logic [7:0] dest);
        case (dest)
            DEST_SERVICE, DEST_ERT_NODE: return 6;
            DEST_EVENT:                  return 8;
            DEST_MODULE:                 return 11;
            DEST_CONTENT:                return 10;
            DEST_CONT_MODULE:            return 13;
            default:                     return 0;
        endcase
    endfunction

    function automatic t_result make_res(input t_kind k, input t_status s, input logic [8:0] bv);
        t_result r;
        r = '0;
        r.kind             = k;
        r.status           = s;
        r.linkage_type     = pr_link;
        r.destination_type = pr_dest;
        r.byte_value       = bv;
        return r;
    endfunction

    task automatic add_expected(input t_result r);
        pending_results = {pending_results, r};
    endtask

    task automatic parse_byte(input logic [7:0] d, input logic sop, input logic eob);
        logic    body_done;
        logic    overrun;
        int      rlen;
        t_result rec;
        overrun = 1'b0;
        if (sop) begin
            pr_count   = '0;
            pr_len     = '0;
            pr_link    = '0;
            pr_dest    = '0;
            pr_sel_len = '0;
            pr_sel_cnt = '0;
            pr_idx     = 0;
            if (eob) begin
                add_expected(make_res(KIND_DONE, ST_SHORT, 9'd0));
                pr_phase = PH_IDLE;
            end else if (d != pr_tag) begin
                add_expected(make_res(KIND_DONE, ST_BAD_TAG, 9'd0));
                pr_phase = PH_IDLE;
            end else begin
                pr_phase = PH_LENGTH;
            end
        end else if (pr_phase == PH_LENGTH) begin
            pr_len = d;
            if (d == 8'd0) begin
                add_expected(make_res(KIND_DONE, ST_ZERO_LEN, 9'd2));
                pr_phase = PH_IDLE;
            end else if (eob) begin
                add_expected(make_res(KIND_DONE, ST_SHORT, 9'd2 + {1'b0, d}));
                pr_phase = PH_IDLE;
            end else begin
                pr_phase = PH_HEADER;
            end
        end else if (pr_phase != PH_IDLE) begin
            pr_count  = pr_count + 8'd1;
            body_done = (pr_count >= pr_len);
            case (pr_phase)
                PH_HEADER: begin
                    if (pr_count == 8'd1) begin
                        pr_link = d;
                    end else if (pr_count == 8'd2) begin
                        pr_dest = d;
                    end else begin
                        pr_sel_len = d;
                        if (3 + int'(pr_sel_len) > int'(pr_len))
                            overrun = 1'b1;
                        else
                            pr_phase = (pr_sel_len != 0) ? PH_SELECT : PH_PRIVATE;
                    end
                    if (body_done && pr_count < 8'd3)
                        overrun = 1'b1;
                end
                PH_SELECT: begin
                    pr_sel_cnt = pr_sel_cnt + 8'd1;
                    rlen = record_len(pr_dest);
                    if (pr_dest == DEST_URI) begin
                        add_expected(make_res(KIND_URI, ST_OK, {1'b0, d}));
                    end else if (rlen != 0) begin
                        pr_rec[pr_idx] = d;
                        pr_idx++;
                        if (pr_idx >= rlen) begin
                            rec = make_res(KIND_RECORD, ST_OK, 9'd0);
                            rec.first_id  = {pr_rec[0], pr_rec[1]};
                            rec.second_id = {pr_rec[2], pr_rec[3]};
                            rec.third_id  = {pr_rec[4], pr_rec[5]};
                            if (pr_dest == DEST_EVENT || pr_dest == DEST_MODULE)
                                rec.event_number = {pr_rec[6], pr_rec[7]};
                            if (pr_dest == DEST_CONTENT || pr_dest == DEST_CONT_MODULE)
                                rec.content_number = {pr_rec[6], pr_rec[7],
                                                      pr_rec[8], pr_rec[9]};
                            if (pr_dest == DEST_MODULE) begin
                                rec.component     = pr_rec[8];
                                rec.module_number = {pr_rec[9], pr_rec[10]};
                            end
                            if (pr_dest == DEST_CONT_MODULE) begin
                                rec.component     = pr_rec[10];
                                rec.module_number = {pr_rec[11], pr_rec[12]};
                            end
                            add_expected(rec);
                            pr_idx = 0;
                        end
                    end
                    // trailing bytes of a partial record are dropped here
                    if (pr_sel_cnt >= pr_sel_len) begin
                        pr_idx   = 0;
                        pr_phase = PH_PRIVATE;
                    end
                end
                default: begin
                    add_expected(make_res(KIND_PRIVATE, ST_OK, {1'b0, d}));
                end
            endcase
            if (eob && !body_done) begin
                add_expected(make_res(KIND_DONE, ST_SHORT, 9'd2 + {1'b0, pr_len}));
                pr_phase = PH_IDLE;
            end else if (overrun) begin
                add_expected(make_res(KIND_DONE, ST_OVERRUN, 9'd2 + {1'b0, pr_len}));
                pr_phase = PH_IDLE;
            end else if (body_done) begin
                add_expected(make_res(KIND_DONE, ST_OK, 9'd2 + {1'b0, pr_len}));
                pr_phase = PH_IDLE;
            end
        end
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, s_tuser, s_tlast);
                beats_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (in_gap != 0) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (byte_backlog.size() != 0 &&
                             !(byte_backlog[0].hold && pending_results.size() != 0)) begin
                    nxt = byte_backlog.pop_front();
                    s_tdata  <= nxt.dbyte;
                    s_tuser  <= nxt.sop;
                    s_tlast  <= nxt.eob;
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 63) == 0)
                        in_calm = !in_calm;
                    in_gap = in_calm ? 0 : $urandom_range(0, 3);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.kind             = t_kind'(m_tuser);
                got.status           = t_status'(m_tdata[2:0]);
                got.linkage_type     = m_tdata[10:3];
                got.destination_type = m_tdata[18:11];
                got.first_id         = m_tdata[34:19];
                got.second_id        = m_tdata[50:35];
                got.third_id         = m_tdata[66:51];
                got.event_number     = m_tdata[82:67];
                got.content_number   = m_tdata[114:83];
                got.component        = m_tdata[122:115];
                got.module_number    = m_tdata[138:123];
                got.byte_value       = m_tdata[147:139];
                if (pending_results.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("[%0t] unexpected result beat: kind %0d status %0d data %h",
                                 $realtime, got.kind, got.status, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind || got.status !== want.status ||
                        got.linkage_type !== want.linkage_type ||
                        got.destination_type !== want.destination_type ||
                        got.first_id !== want.first_id || got.second_id !== want.second_id ||
                        got.third_id !== want.third_id ||
                        got.event_number !== want.event_number ||
                        got.content_number !== want.content_number ||
                        got.component !== want.component ||
                        got.module_number !== want.module_number ||
                        got.byte_value !== want.byte_value) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("[%0t] mismatch: exp kind %0d status %0d bv %0d fields %h",
                                     $realtime, want.kind, want.status, want.byte_value, want);
                            $display("[%0t]           got kind %0d status %0d bv %0d fields %h",
                                     $realtime, got.kind, got.status, got.byte_value, got);
                        end
                    end
                end
                if (got.kind !== 2'bx)
                    kind_seen[got.kind]++;
                if ($urandom_range(0, 63) == 0)
                    out_calm = !out_calm;
                out_gap = out_calm ? 0 : $urandom_range(0, 3);
            end
            if (out_gap != 0) begin
                out_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic queue_byte(input logic [7:0] d, input logic sop, input logic eob,
                              input bit hold);
        t_beat_item it;
        it.dbyte = d;
        it.sop   = sop;
        it.eob   = eob;
        it.hold  = hold;
        byte_backlog = {byte_backlog, it};
    endtask

    // cut = 0 or cut >= 2 + len sends the whole descriptor, else only its first cut bytes
    task automatic queue_desc(input logic [7:0] tag, input int len, input logic [7:0] dest,
                              input int sel, input int cut, input bit eob, input bit hold);
        int         total;
        int         n;
        logic [7:0] b;
        total = 2 + len;
        n = (cut > 0 && cut < total) ? cut : total;
        for (int i = 0; i < n; i++) begin
            case (i)
                0:       b = tag;
                1:       b = 8'(len);
                3:       b = dest;
                4:       b = 8'(sel);
                default: b = 8'($urandom_range(0, 255));
            endcase
            queue_byte(b, i == 0, eob && i == n - 1, hold && i == 0);
            bytes_queued++;
        end
    endtask

    task automatic queue_random_desc(input logic [7:0] tag, input bit hold);
        int         p;
        int         rlen;
        int         len;
        int         sel;
        int         priv;
        int         cut;
        logic [7:0] dest;
        logic [7:0] t;
        bit         eob;
        p = $urandom_range(0, 15);
        if (p < 14)
            dest = 8'(p % 7 + 1);
        else if (p == 14)
            dest = 8'h00;
        else
            dest = 8'($urandom_range(8, 255));
        rlen = record_len(dest);
        if (rlen != 0) begin
            sel = $urandom_range(0, 3) * rlen;
            if ($urandom_range(0, 3) == 0)
                sel += $urandom_range(1, rlen - 1);
        end else begin
            sel = $urandom_range(0, 8);
        end
        priv = $urandom_range(0, 5);
        len  = 3 + sel + priv;
        t    = tag;
        cut  = 0;
        eob  = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) < 3) begin
            case ($urandom_range(0, 5))
                0: begin
                    t   = tag ^ 8'($urandom_range(1, 255));
                    cut = 1;
                end
                1: len = 0;
                2: len = $urandom_range(1, 2);
                3: begin
                    sel = $urandom_range(len - 2, 255);
                    cut = 5;
                end
                4: begin
                    cut = $urandom_range(1, len + 1);
                    eob = 1'b1;
                end
                default: begin
                    cut = $urandom_range(1, len + 1);
                    eob = 1'b0;
                end
            endcase
        end
        queue_desc(t, len, dest, sel, cut, eob, hold);
        if ($urandom_range(0, 19) == 0)
            queue_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)), 1'b0);
    endtask

    task automatic wait_drained();
        while (byte_backlog.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_tag(input logic [7:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({REG_EXPECTED_TAG, 2'b00});
        pwdata  <= {24'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pr_tag = v;
        tags_used++;
    endtask

    initial begin
        logic [7:0] tag_now;
        int         stop;
        bit         held;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tags_used = 1;

        // directed part, reset tag
        queue_byte(8'h5A, 1'b0, 1'b0, 1'b0);                      // stray byte while waiting
        queue_byte(TAG_RESET, 1'b1, 1'b1, 1'b0);                  // buffer ends on the tag
        queue_byte(8'h00, 1'b1, 1'b0, 1'b0);                      // bad tag, low extreme
        queue_byte(8'hFF, 1'b1, 1'b0, 1'b0);                      // bad tag, high extreme
        queue_desc(TAG_RESET, 0, 8'h00, 0, 0, 1'b1, 1'b0);        // zero length beats end
        queue_desc(TAG_RESET, 1, DEST_SERVICE, 0, 0, 1'b0, 1'b0); // body ends before sel length
        queue_desc(TAG_RESET, 20, DEST_URI, 4, 2, 1'b1, 1'b0);    // buffer ends on length
        queue_desc(TAG_RESET, 10, DEST_ERT_NODE, 7, 0, 1'b1, 1'b0); // record plus partial
        queue_desc(TAG_RESET, 5, DEST_URI, 1, 0, 1'b0, 1'b0);     // URI and private bytes
        queue_desc(TAG_RESET, 3, DEST_EVENT, 255, 0, 1'b0, 1'b0); // selector overrun
        queue_desc(TAG_RESET, 10, DEST_URI, 4, 3, 1'b0, 1'b0);    // restart mid-descriptor
        queue_desc(TAG_RESET, 4, 8'h00, 0, 5, 1'b1, 1'b0);        // buffer short in header
        queue_desc(TAG_RESET, 6, 8'hFF, 2, 0, 1'b0, 1'b0);        // unknown type skipped
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0:       tag_now = 8'h00;
                1:       tag_now = 8'hFF;
                3:       tag_now = TAG_RESET;
                default: tag_now = 8'($urandom_range(0, 255));
            endcase
            write_tag(tag_now);
            if (ph == 2)
                queue_desc(tag_now, 255, DEST_URI, $urandom_range(0, 252), 0, 1'b1, 1'b0);
            stop = bytes_queued + 110;
            held = 1'b0;
            while (bytes_queued < stop) begin
                queue_random_desc(tag_now, !held && bytes_queued >= stop - 55);
                if (bytes_queued >= stop - 55)
                    held = 1'b1;
            end
            // leave the parser idle before the next register write
            queue_desc(tag_now, 9, DEST_SERVICE, 6, 0, 1'b0, 1'b0);
            wait_drained();
        end

        $display("Covered %0d input beats under %0d expected-tag settings, 0x00 and 0xFF included",
                 beats_taken, tags_used);
        $display("Checked %0d records, %0d URI bytes, %0d private bytes, %0d done beats",
                 kind_seen[KIND_RECORD], kind_seen[KIND_URI], kind_seen[KIND_PRIVATE],
                 kind_seen[KIND_DONE]);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- hyperlink_descriptor_parser_top.f -----
+incdir+design
design/hdp_pkg.sv
design/hdp_front.sv
design/hdp_queue.sv
design/hdp_back.sv
design/hyperlink_descriptor_parser_top.sv
design/hdp_checker.sv
bench/hyperlink_descriptor_parser_top_tb.sv
